@@ rtl/mfmd_pkg.sv @@
// Shared constants and register indexes for the multi-turn feedback decoder.
// No dependencies; every other file in rtl imports this package.
package mfmd_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned ENC_W     = 16;
   localparam int unsigned SAMPLE_W  = 16;
   localparam int unsigned WEIGHT_W  = 17;
   localparam int unsigned SCALE_W   = 24;
   localparam int unsigned SINGLE_W  = 32;
   localparam int unsigned TURN_W    = 24;
   localparam int unsigned TOTAL_W   = 49;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DAT_W = 24;

   // Q0.16 unity weight
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

   // Q8.16 degrees per count after reset (360/8192)
   localparam logic [SCALE_W-1:0] ANGLE_SCALE_RESET = 24'd2880;

   // Encoder jump that counts as a wrap
   localparam logic signed [ENC_W:0] TURN_JUMP = 17'sd4096;

   localparam logic signed [TURN_W-1:0] TURN_MAX = 24'sh7FFFFF;
   localparam logic signed [TURN_W-1:0] TURN_MIN = 24'sh800000;

   // Degrees per turn, integer part of the Q16.16 full-turn angle
   localparam logic signed [9:0] DEG_PER_TURN = 10'sd360;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_WEIGHT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURRENT_WEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_SCALE    = 2'd2;

endpackage

@@ rtl/mfmd_if.sv @@
// Valid/ready channel interfaces: feedback frame request, decoded response
// and register write port. Depends on mfmd_pkg for widths.
interface mfmd_req_if;
   import mfmd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] frame_byte0;
   logic [BYTE_W-1:0] frame_byte1;
   logic [BYTE_W-1:0] frame_byte2;
   logic [BYTE_W-1:0] frame_byte3;
   logic [BYTE_W-1:0] frame_byte4;
   logic [BYTE_W-1:0] frame_byte5;
   logic [BYTE_W-1:0] frame_byte6;

   modport source (output valid, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
                   frame_byte4, frame_byte5, frame_byte6, input ready);
   modport sink   (input valid, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
                   frame_byte4, frame_byte5, frame_byte6, output ready);
endinterface

interface mfmd_rsp_if;
   import mfmd_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [ENC_W-1:0]           encoder_position;
   logic [SINGLE_W-1:0]        single_turn_angle;
   logic signed [SAMPLE_W-1:0] filtered_speed;
   logic signed [SAMPLE_W-1:0] filtered_current;
   logic [BYTE_W-1:0]          temperature;
   logic signed [TURN_W-1:0]   turn_count;
   logic signed [TOTAL_W-1:0]  absolute_angle;

   modport source (output valid, encoder_position, single_turn_angle, filtered_speed,
                   filtered_current, temperature, turn_count, absolute_angle,
                   input ready);
   modport sink   (input valid, encoder_position, single_turn_angle, filtered_speed,
                   filtered_current, temperature, turn_count, absolute_angle,
                   output ready);
endinterface

interface mfmd_csr_if;
   import mfmd_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] reg_index;
   logic [CSR_DAT_W-1:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ rtl/mfmd_smoother.sv @@
// First-order exponential smoother, Q0.16 weight, truncation toward zero.
// Depends on mfmd_pkg.
module mfmd_smoother (
   input  logic signed [mfmd_pkg::SAMPLE_W-1:0] old_val,
   input  logic signed [mfmd_pkg::SAMPLE_W-1:0] sample,
   input  logic        [mfmd_pkg::WEIGHT_W-1:0] weight,
   output logic signed [mfmd_pkg::SAMPLE_W-1:0] new_val
);
   import mfmd_pkg::*;

   logic        [WEIGHT_W-1:0] w_eff;
   logic signed [SAMPLE_W:0]   delta;
   logic signed [35:0]         prod;
   logic signed [35:0]         acc;
   logic signed [19:0]         quot;

   // f' = (65536*f + w*(x - f)) / 65536
   assign w_eff = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
   assign delta = 17'(sample) - 17'(old_val);

   always_comb begin
      prod = 36'(signed'({1'b0, w_eff})) * 36'(delta);
      acc  = {{4{old_val[SAMPLE_W-1]}}, old_val, 16'd0} + prod;
      quot = acc[35:16];
      // floor to truncation: bump negative values with a remainder
      if (acc[35] && (acc[15:0] != 16'd0)) begin
         quot = quot + 20'sd1;
      end
      new_val = quot[SAMPLE_W-1:0];
   end

endmodule

@@ rtl/motor_feedback_multiturn_decoder_top.sv @@
// Multi-turn motor feedback decoder: frame input register, one pass of
// decode logic, response register. Depends on mfmd_pkg, mfmd_if, mfmd_smoother.
//
// Requests pass the input register, then the response register driving rsp
// (two register stages). Throughput: one request per cycle, set by the single
// registered pass; rsp ready reaches req ready combinationally, so a stalled
// response holds off new requests once the input stage is also full.
// Reset (synchronous, active high) clears valids, encoder history, turn
// counter, both filters and the registers (angle_scale back to 2880).
module motor_feedback_multiturn_decoder_top (
   input  logic       clock,
   input  logic       reset,
   mfmd_req_if.sink   req_bus,
   mfmd_rsp_if.source rsp_bus,
   mfmd_csr_if.sink   csr_bus
);
   import mfmd_pkg::*;

   // ---------------------------------------------------------------
   // Configuration registers; writes are always accepted
   // ---------------------------------------------------------------
   logic [WEIGHT_W-1:0] speed_weight_ff;
   logic [WEIGHT_W-1:0] current_weight_ff;
   logic [SCALE_W-1:0]  angle_scale_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_weight_ff   <= '0;
         current_weight_ff <= '0;
         angle_scale_ff    <= ANGLE_SCALE_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            CSR_SPEED_WEIGHT:   speed_weight_ff   <= csr_bus.wdata[WEIGHT_W-1:0];
            CSR_CURRENT_WEIGHT: current_weight_ff <= csr_bus.wdata[WEIGHT_W-1:0];
            CSR_ANGLE_SCALE:    angle_scale_ff    <= csr_bus.wdata[SCALE_W-1:0];
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake: the input stage advances into the response register
   // whenever that register is empty or being drained this cycle.
   // ---------------------------------------------------------------
   logic in_valid_ff;
   logic out_valid_ff;
   logic advance;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // Input register: hold the frame bytes of the accepted request
   // ---------------------------------------------------------------
   logic [ENC_W-1:0]           enc_ff;
   logic signed [SAMPLE_W-1:0] speed_ff;
   logic signed [SAMPLE_W-1:0] current_ff;
   logic [BYTE_W-1:0]          temp_ff;

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         enc_ff     <= {req_bus.frame_byte0, req_bus.frame_byte1};
         speed_ff   <= {req_bus.frame_byte2, req_bus.frame_byte3};
         current_ff <= {req_bus.frame_byte4, req_bus.frame_byte5};
         temp_ff    <= req_bus.frame_byte6;
      end
   end

   // ---------------------------------------------------------------
   // Decoder state, updated as each frame passes into the response
   // ---------------------------------------------------------------
   logic [ENC_W-1:0]           prev_enc_ff;
   logic signed [TURN_W-1:0]   turn_ff;
   logic signed [SAMPLE_W-1:0] speed_filt_ff;
   logic signed [SAMPLE_W-1:0] current_filt_ff;

   logic signed [TURN_W-1:0]   turn_in;
   logic signed [SAMPLE_W-1:0] speed_filt_in;
   logic signed [SAMPLE_W-1:0] current_filt_in;

   mfmd_smoother u_speed_smoother (
      .old_val (speed_filt_ff),
      .sample  (speed_ff),
      .weight  (speed_weight_ff),
      .new_val (speed_filt_in)
   );

   mfmd_smoother u_current_smoother (
      .old_val (current_filt_ff),
      .sample  (current_ff),
      .weight  (current_weight_ff),
      .new_val (current_filt_in)
   );

   // Turn detection: a large forward jump means the count wrapped downward
   logic signed [ENC_W:0] enc_delta;

   assign enc_delta = signed'({1'b0, enc_ff}) - signed'({1'b0, prev_enc_ff});

   always_comb begin
      turn_in = turn_ff;
      if (enc_delta > TURN_JUMP) begin
         if (turn_ff != TURN_MIN) begin
            turn_in = turn_ff - 24'sd1;
         end
      end else if (enc_delta < -TURN_JUMP) begin
         if (turn_ff != TURN_MAX) begin
            turn_in = turn_ff + 24'sd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_enc_ff     <= '0;
         turn_ff         <= '0;
         speed_filt_ff   <= '0;
         current_filt_ff <= '0;
      end else if (advance) begin
         prev_enc_ff     <= enc_ff;
         turn_ff         <= turn_in;
         speed_filt_ff   <= speed_filt_in;
         current_filt_ff <= current_filt_in;
      end
   end

   // ---------------------------------------------------------------
   // Angles: single-turn product saturates at 32 bits; total angle adds
   // whole turns times 360 degrees in the integer part of Q16.16.
   // ---------------------------------------------------------------
   logic [ENC_W+SCALE_W-1:0]   angle_prod;
   logic [SINGLE_W-1:0]        single_in;
   logic signed [32:0]         turn_deg;
   logic signed [TOTAL_W:0]    total_wide;
   logic signed [TOTAL_W-1:0]  total_in;

   assign angle_prod = (ENC_W+SCALE_W)'(enc_ff) * (ENC_W+SCALE_W)'(angle_scale_ff);
   assign single_in  = (angle_prod[ENC_W+SCALE_W-1:SINGLE_W] != '0) ? '1
                                                                     : angle_prod[SINGLE_W-1:0];
   assign turn_deg   = 33'(turn_in) * 33'(DEG_PER_TURN);
   assign total_wide = signed'({turn_deg[32], turn_deg, 16'd0})
                     + signed'({18'd0, single_in});
   assign total_in   = total_wide[TOTAL_W-1:0];

   // ---------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------
   logic [ENC_W-1:0]           rsp_enc_ff;
   logic [SINGLE_W-1:0]        rsp_single_ff;
   logic signed [SAMPLE_W-1:0] rsp_speed_ff;
   logic signed [SAMPLE_W-1:0] rsp_current_ff;
   logic [BYTE_W-1:0]          rsp_temp_ff;
   logic signed [TURN_W-1:0]   rsp_turn_ff;
   logic signed [TOTAL_W-1:0]  rsp_total_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_enc_ff     <= enc_ff;
         rsp_single_ff  <= single_in;
         rsp_speed_ff   <= speed_filt_in;
         rsp_current_ff <= current_filt_in;
         rsp_temp_ff    <= temp_ff;
         rsp_turn_ff    <= turn_in;
         rsp_total_ff   <= total_in;
      end
   end

   assign rsp_bus.valid             = out_valid_ff;
   assign rsp_bus.encoder_position  = rsp_enc_ff;
   assign rsp_bus.single_turn_angle = rsp_single_ff;
   assign rsp_bus.filtered_speed    = rsp_speed_ff;
   assign rsp_bus.filtered_current  = rsp_current_ff;
   assign rsp_bus.temperature       = rsp_temp_ff;
   assign rsp_bus.turn_count        = rsp_turn_ff;
   assign rsp_bus.absolute_angle    = rsp_total_ff;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for motor_feedback_multiturn_decoder_top: directed and random
// feedback frames under random back-pressure, checked against an in-bench decode predictor.
// Depends on rtl/mfmd_pkg.sv, rtl/mfmd_if.sv and the decoder RTL.
`timescale 1ns / 100ps

module tb_top;
   import mfmd_pkg::*;

   // Register index past the end of the map; writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   // Q16.16 angle of one full turn
   localparam longint FULL_TURN_Q16 = longint'(DEG_PER_TURN) * 65536;

   localparam int unsigned MAX_REPORTS  = 10;
   localparam int unsigned RANDOM_PHASES = 12;
   localparam int unsigned PHASE_FRAMES  = 154;

   typedef struct packed {
      logic [BYTE_W-1:0] byte0;
      logic [BYTE_W-1:0] byte1;
      logic [BYTE_W-1:0] byte2;
      logic [BYTE_W-1:0] byte3;
      logic [BYTE_W-1:0] byte4;
      logic [BYTE_W-1:0] byte5;
      logic [BYTE_W-1:0] byte6;
   } frame_type;

   typedef struct packed {
      logic [ENC_W-1:0]           encoder_position;
      logic [SINGLE_W-1:0]        single_turn_angle;
      logic signed [SAMPLE_W-1:0] filtered_speed;
      logic signed [SAMPLE_W-1:0] filtered_current;
      logic [BYTE_W-1:0]          temperature;
      logic signed [TURN_W-1:0]   turn_count;
      logic signed [TOTAL_W-1:0]  absolute_angle;
   } decoded_type;

   // Tracks decoder state and registers, predicts each decoded frame and
   // compares the responses in order.
   class decode_tracker;
      logic [WEIGHT_W-1:0]        speed_weight;
      logic [WEIGHT_W-1:0]        current_weight;
      logic [SCALE_W-1:0]         angle_scale;
      logic [ENC_W-1:0]           last_encoder;
      logic signed [TURN_W-1:0]   turns;
      logic signed [SAMPLE_W-1:0] speed_avg;
      logic signed [SAMPLE_W-1:0] current_avg;
      decoded_type                pending_decodes[$];
      int unsigned                failures;

      function new();
         speed_weight   = '0;
         current_weight = '0;
         angle_scale    = ANGLE_SCALE_RESET;
         last_encoder   = '0;
         turns          = '0;
         speed_avg      = '0;
         current_avg    = '0;
         failures       = 0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DAT_W-1:0] data);
         case (index)
            CSR_SPEED_WEIGHT:   speed_weight   = data[WEIGHT_W-1:0];
            CSR_CURRENT_WEIGHT: current_weight = data[WEIGHT_W-1:0];
            CSR_ANGLE_SCALE:    angle_scale    = data[SCALE_W-1:0];
            default: ;
         endcase
      endfunction

      // Exponential smoother, exact product sum, truncated toward zero
      function logic signed [SAMPLE_W-1:0] smooth(logic signed [SAMPLE_W-1:0] prior,
                                                   logic signed [SAMPLE_W-1:0] fresh,
                                                   logic [WEIGHT_W-1:0] weight);
         longint w;
         longint acc;
         w   = (weight > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(weight);
         acc = (longint'(WEIGHT_ONE) - w) * longint'(prior) + w * longint'(fresh);
         return SAMPLE_W'(acc / longint'(WEIGHT_ONE));
      endfunction

      function void note_frame(frame_type f);
         decoded_type      d;
         logic [ENC_W-1:0] enc;
         int               jump;
         logic [63:0]      product;
         longint           total;
         enc     = {f.byte0, f.byte1};
         jump    = int'(enc) - int'(last_encoder);
         product = 64'(enc) * 64'(angle_scale);
         d.encoder_position  = enc;
         d.single_turn_angle = (product > 64'hFFFF_FFFF) ? '1 : product[SINGLE_W-1:0];
         speed_avg   = smooth(speed_avg, {f.byte2, f.byte3}, speed_weight);
         current_avg = smooth(current_avg, {f.byte4, f.byte5}, current_weight);
         if (jump > int'(TURN_JUMP)) begin
            if (turns != TURN_MIN) turns = turns - 24'sd1;
         end else if (jump < -int'(TURN_JUMP)) begin
            if (turns != TURN_MAX) turns = turns + 24'sd1;
         end
         last_encoder = enc;
         total = longint'(turns) * FULL_TURN_Q16 + longint'(d.single_turn_angle);
         d.filtered_speed   = speed_avg;
         d.filtered_current = current_avg;
         d.temperature      = f.byte6;
         d.turn_count       = turns;
         d.absolute_angle   = total[TOTAL_W-1:0];
         pending_decodes.push_back(d);
      endfunction

      function void note_mismatch(string what, longint want, longint seen);
         failures++;
         if (failures <= MAX_REPORTS)
            $display("ERROR: %s expected %0d got %0d", what, want, seen);
      endfunction

      function void check_decoded(decoded_type got);
         decoded_type want;
         if (pending_decodes.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("ERROR: response with no request outstanding, encoder_position %0d",
                        got.encoder_position);
            return;
         end
         want = pending_decodes.pop_front();
         if (got.encoder_position !== want.encoder_position)
            note_mismatch("encoder_position", want.encoder_position, got.encoder_position);
         if (got.single_turn_angle !== want.single_turn_angle)
            note_mismatch("single_turn_angle", want.single_turn_angle, got.single_turn_angle);
         if (got.filtered_speed !== want.filtered_speed)
            note_mismatch("filtered_speed", want.filtered_speed, got.filtered_speed);
         if (got.filtered_current !== want.filtered_current)
            note_mismatch("filtered_current", want.filtered_current, got.filtered_current);
         if (got.temperature !== want.temperature)
            note_mismatch("temperature", want.temperature, got.temperature);
         if (got.turn_count !== want.turn_count)
            note_mismatch("turn_count", want.turn_count, got.turn_count);
         if (got.absolute_angle !== want.absolute_angle)
            note_mismatch("absolute_angle", want.absolute_angle, got.absolute_angle);
      endfunction

      function int unsigned outstanding();
         return pending_decodes.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   mfmd_req_if req_bus ();
   mfmd_rsp_if rsp_bus ();
   mfmd_csr_if csr_bus ();

   motor_feedback_multiturn_decoder_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   decode_tracker    tracker;
   bit               quiet;      // suppress idling on both sides
   logic [ENC_W-1:0] walk_pos;   // encoder position of the simulated rotor

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly no gap, often a short one, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic frame_type make_frame(logic [15:0] enc, logic [15:0] speed,
                                            logic [15:0] current, logic [7:0] temp);
      return {enc, speed, current, temp};
   endfunction

   // Favor the signed extremes, zero and minus one
   function automatic logic [15:0] pick_sample();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h8000;
      if (r == 1) return 16'h7FFF;
      if (r == 2) return 16'h0000;
      if (r == 3) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // Mostly a rotor turning on a 13-bit encoder, so wraps count turns; then
   // wide 16-bit swings, jumps right at the turn threshold, and pure noise.
   function automatic frame_type random_frame();
      int unsigned r;
      int          step;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         step     = int'($urandom_range(0, 1200)) - 600;
         walk_pos = 16'((int'(walk_pos) + step) & 8191);
      end else if (r < 75) begin
         walk_pos = walk_pos + 16'(int'($urandom_range(0, 40000)) - 20000);
      end else if (r < 87) begin
         step = int'($urandom_range(4094, 4098));
         if ($urandom_range(0, 1) == 1) step = -step;
         walk_pos = walk_pos + 16'(step);
      end else begin
         walk_pos = 16'($urandom);
      end
      return make_frame(walk_pos, pick_sample(), pick_sample(), 8'($urandom));
   endfunction

   // Zero, unity, above unity (clamped) or anything in range
   function automatic logic [WEIGHT_W-1:0] pick_weight();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 2) return '0;
      if (r < 4) return WEIGHT_ONE;
      if (r == 4) return WEIGHT_W'($urandom_range(65537, 131071));
      return WEIGHT_W'($urandom_range(0, 65536));
   endfunction

   function automatic logic [SCALE_W-1:0] pick_scale();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 2) return '0;
      if (r == 2) return '1;
      if (r < 5) return ANGLE_SCALE_RESET;
      return SCALE_W'($urandom);
   endfunction

   // Sample all three handshakes at the rising edge. A response always comes
   // from a request of an earlier edge, so check before noting.
   always @(posedge clock) begin : sample_edge
      decoded_type got;
      frame_type   f;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.encoder_position  = rsp_bus.encoder_position;
            got.single_turn_angle = rsp_bus.single_turn_angle;
            got.filtered_speed    = rsp_bus.filtered_speed;
            got.filtered_current  = rsp_bus.filtered_current;
            got.temperature       = rsp_bus.temperature;
            got.turn_count        = rsp_bus.turn_count;
            got.absolute_angle    = rsp_bus.absolute_angle;
            tracker.check_decoded(got);
         end
         if (req_bus.valid && req_bus.ready) begin
            f = {req_bus.frame_byte0, req_bus.frame_byte1, req_bus.frame_byte2,
                 req_bus.frame_byte3, req_bus.frame_byte4, req_bus.frame_byte5,
                 req_bus.frame_byte6};
            tracker.note_frame(f);
         end
         if (csr_bus.valid && csr_bus.ready)
            tracker.write_register(csr_bus.reg_index, csr_bus.wdata);
      end
   end

   // Response side: toggle ready in random runs, hold it high while quiet
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         int unsigned gap;
         @(negedge clock);
         gap = pick_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   // Present one request and hold it until accepted. With no gap, valid
   // stays high into the next call, which only reloads the bytes.
   task automatic send_frame(frame_type f);
      int unsigned gap;
      req_bus.valid       <= 1'b1;
      req_bus.frame_byte0 <= f.byte0;
      req_bus.frame_byte1 <= f.byte1;
      req_bus.frame_byte2 <= f.byte2;
      req_bus.frame_byte3 <= f.byte3;
      req_bus.frame_byte4 <= f.byte4;
      req_bus.frame_byte5 <= f.byte5;
      req_bus.frame_byte6 <= f.byte6;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // One register write; drop valid and wait again before returning so the next
   // write raises valid in a later step than this one drops it.
   task automatic write_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DAT_W-1:0] data);
      csr_bus.valid     <= 1'b1;
      csr_bus.reg_index <= index;
      csr_bus.wdata     <= data;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Drop valid and hold off until every outstanding request has its response
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   initial begin
      tracker  = new();
      quiet    = 1'b0;
      walk_pos = '0;

      // Drive every input to a known value before the first edge
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.frame_byte0 = '0;
      req_bus.frame_byte1 = '0;
      req_bus.frame_byte2 = '0;
      req_bus.frame_byte3 = '0;
      req_bus.frame_byte4 = '0;
      req_bus.frame_byte5 = '0;
      req_bus.frame_byte6 = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.reg_index   = '0;
      csr_bus.wdata       = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset registers: weights zero keep both filters at zero, default scale.
      // Walk the turn threshold: exactly 4096 either way counts nothing,
      // one more counts a turn. The first frame starts from encoder zero.
      send_frame(make_frame(16'h0000, 16'h7FFF, 16'h8000, 8'h00));
      send_frame(make_frame(16'd4096, 16'h8000, 16'h7FFF, 8'hFF));
      send_frame(make_frame(16'h0000, 16'h0000, 16'hFFFF, 8'h01));
      send_frame(make_frame(16'd4097, 16'hFFFF, 16'h0000, 8'h80));
      send_frame(make_frame(16'h0000, 16'h1234, 16'hEDCB, 8'h7F));
      send_frame(make_frame(16'hFFFF, 16'hFFFF, 16'h0001, 8'hA5));
      send_frame(make_frame(16'd8191, 16'h5555, 16'hAAAA, 8'h5A));
      drain();

      // Unity speed weight, current weight above unity (clamps to unity),
      // full-scale angle so the single-turn product saturates. The unmapped
      // index must leave everything alone.
      write_register(CSR_SPEED_WEIGHT, 24'(WEIGHT_ONE));
      write_register(CSR_CURRENT_WEIGHT, 24'hFFFFFF);
      write_register(CSR_ANGLE_SCALE, 24'hFFFFFF);
      write_register(CSR_UNMAPPED, 24'h5A5A5A);
      send_frame(make_frame(16'hFFFF, 16'h7FFF, 16'h8000, 8'h10));
      send_frame(make_frame(16'd256, 16'h8000, 16'h7FFF, 8'h20));
      send_frame(make_frame(16'd257, 16'h7FFF, 16'h8000, 8'h30));
      send_frame(make_frame(16'h0000, 16'h8000, 16'h7FFF, 8'h40));
      drain();

      // Smallest nonzero weight against a zero weight, zero angle scale
      write_register(CSR_SPEED_WEIGHT, 24'd1);
      write_register(CSR_CURRENT_WEIGHT, 24'd0);
      write_register(CSR_ANGLE_SCALE, 24'd0);
      send_frame(make_frame(16'd40000, 16'h7FFF, 16'h1234, 8'hC3));
      send_frame(make_frame(16'd40000, 16'h8000, 16'h8000, 8'h3C));
      send_frame(make_frame(16'h0000, 16'h8000, 16'h7FFF, 8'hFF));
      drain();

      // Half weights and the reset scale
      write_register(CSR_SPEED_WEIGHT, 24'd32768);
      write_register(CSR_CURRENT_WEIGHT, 24'd32768);
      write_register(CSR_ANGLE_SCALE, 24'(ANGLE_SCALE_RESET));
      send_frame(make_frame(16'd8191, 16'h7FFF, 16'h8000, 8'h00));
      send_frame(make_frame(16'd100, 16'h8001, 16'h7FFE, 8'hFF));
      send_frame(make_frame(16'd8000, 16'hFFFF, 16'h0001, 8'h99));
      drain();

      // Random phases, each under a fresh register setting. Upper data bits
      // beyond each weight register are random and must be ignored.
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_register(CSR_SPEED_WEIGHT, {7'($urandom), pick_weight()});
         write_register(CSR_CURRENT_WEIGHT, {7'($urandom), pick_weight()});
         write_register(CSR_ANGLE_SCALE, pick_scale());
         if ($urandom_range(0, 3) == 0)
            write_register(CSR_UNMAPPED, 24'($urandom));
         quiet = (phase % 4 == 1);
         for (int unsigned i = 0; i < PHASE_FRAMES; i++) begin
            // Stall the sender mid-phase until the pipe is empty
            if (phase == 2 && i == PHASE_FRAMES / 2)
               drain();
            send_frame(random_frame());
         end
         drain();
         quiet = 1'b0;
      end

      repeat (10) @(posedge clock);
      if (tracker.failures == 0 && tracker.outstanding() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/mfmd_pkg.sv
rtl/mfmd_if.sv
rtl/mfmd_smoother.sv
rtl/motor_feedback_multiturn_decoder_top.sv
tb/tb_top.sv
